### sv/rbp_pkg.sv
// Package for the byte to slot bit repacker.
// Holds widths, register constants and the request struct shared by the modules.
// No dependencies.
package rbp_pkg;

  localparam int BYTE_W = 8;
  localparam int WORD_W = 31;
  localparam int ACC_W  = 38;
  localparam int HELD_W = 6;
  localparam int CFG_W  = 6;
  localparam int D_W    = 5;

  localparam logic [CFG_W-1:0] PMB_RESET = 6'd17;
  localparam logic [CFG_W-1:0] PMB_MIN   = 6'd2;
  localparam logic [CFG_W-1:0] PMB_MAX   = 6'd32;

  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] word;
    logic              last;
  } emit_t;

endpackage

### sv/rbp_ifs.sv
// Channel interfaces for the byte to slot bit repacker.
// Depends on rbp_pkg for the field widths.
interface rbp_byte_if import rbp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              end_of_segment;

  modport source (output valid, output data_byte, output end_of_segment, input ready);
  modport sink (input valid, input data_byte, input end_of_segment, output ready);
endinterface

interface rbp_word_if import rbp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] slot_word;
  logic              segment_last;

  modport source (output valid, output slot_word, output segment_last, input ready);
  modport sink (input valid, input slot_word, input segment_last, output ready);
endinterface

### sv/rbp_accum.sv
// Bit accumulator: appends accepted bytes and cuts one word per cycle if out_free.
// Depends on rbp_pkg and the rbp_byte_if interface.
module rbp_accum import rbp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  logic [D_W-1:0]    word_bits,
  rbp_byte_if.sink          byte_in,
  input  logic              out_free,
  output emit_t             emit
);

  logic [ACC_W-1:0]  acc;
  logic [HELD_W-1:0] held;
  logic              end_pend;

  logic [HELD_W-1:0] d6;
  logic              full;
  logic [HELD_W-1:0] shift;
  logic [ACC_W-1:0]  shifted;
  logic [D_W-1:0]    pad_n;
  logic [WORD_W:0]   dmask_w;
  logic [WORD_W:0]   pmask_w;
  logic [WORD_W-1:0] w_full;
  logic [WORD_W-1:0] w_pad;
  logic              fire;
  logic [HELD_W-1:0] held_post;
  logic              end_post;
  logic              accept;

  always_comb begin
    d6       = {1'b0, word_bits};
    full     = held >= d6;
    shift    = held - d6;
    shifted  = acc >> shift;
    pad_n    = word_bits - held[D_W-1:0];
    dmask_w  = ({{WORD_W{1'b0}}, 1'b1} << word_bits) - 1'b1;
    pmask_w  = ({{WORD_W{1'b0}}, 1'b1} << pad_n) - 1'b1;
    w_full   = shifted[WORD_W-1:0] & dmask_w[WORD_W-1:0];
    w_pad    = ((acc[WORD_W-1:0] << pad_n) | pmask_w[WORD_W-1:0]) & dmask_w[WORD_W-1:0];

    emit.valid = full || (end_pend && (held != '0));
    emit.word  = full ? w_full : w_pad;
    emit.last  = full ? (end_pend && (held == d6)) : 1'b1;

    fire      = emit.valid && out_free;
    held_post = held;
    end_post  = end_pend;
    if (fire) begin
      held_post = full ? shift : '0;
      if (emit.last) begin
        end_post = 1'b0;
      end
    end
    byte_in.ready = (held_post < d6) && !end_post;
    accept        = byte_in.valid && byte_in.ready;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      acc      <= '0;
      held     <= '0;
      end_pend <= 1'b0;
    end else begin
      held     <= held_post;
      end_pend <= end_post;
      if (accept) begin
        acc      <= {acc[ACC_W-BYTE_W-1:0], byte_in.data_byte};
        held     <= held_post + HELD_W'(BYTE_W);
        end_pend <= byte_in.end_of_segment;
      end
    end
  end

endmodule

### sv/rbp_out_reg.sv
// Result register: holds one word request until the downstream side takes it.
// Depends on rbp_pkg and the rbp_word_if interface.
module rbp_out_reg import rbp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  emit_t     emit,
  output logic      out_free,
  rbp_word_if.source word_out
);

  logic              valid;
  logic [WORD_W-1:0] word;
  logic              last;

  assign out_free              = !valid || word_out.ready;
  assign word_out.valid        = valid;
  assign word_out.slot_word    = word;
  assign word_out.segment_last = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (out_free) begin
      valid <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit.valid) begin
      word <= emit.word;
      last <= emit.last;
    end
  end

endmodule

### sv/byte_to_slot_bit_repacker_unit.sv
// Byte to slot bit repacker: packs an MSB-first byte stream into words of
// plain_modulus_bits - 1 bits (setting clamped to 2..32), padding the tail of
// each segment with ones. The unit emits one word per cycle while the output
// side is free and takes a byte whenever the bits left after this cycle's word
// are fewer than a word and no segment end is pending, so with words of eight
// or more bits it sustains one byte per cycle, a segment end whose byte leaves
// bits beyond a full word holding the input while its pad word goes out; with
// words below eight bits the single word output sets the byte rate. Words are
// registered at the output. A configuration write drops any partial word and
// restarts the stream.
module byte_to_slot_bit_repacker_unit import rbp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  rbp_byte_if.sink         byte_in,
  rbp_word_if.source       word_out,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  logic [CFG_W-1:0] plain_modulus_bits;
  logic [CFG_W-1:0] pmb_clamped;
  logic [D_W-1:0]   word_bits;
  logic [CFG_W-1:0] d_full;
  emit_t            emit;
  logic             out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      plain_modulus_bits <= PMB_RESET;
    end else if (cfg_we) begin
      plain_modulus_bits <= cfg_wdata;
    end
  end

  always_comb begin
    if (plain_modulus_bits < PMB_MIN) begin
      pmb_clamped = PMB_MIN;
    end else if (plain_modulus_bits > PMB_MAX) begin
      pmb_clamped = PMB_MAX;
    end else begin
      pmb_clamped = plain_modulus_bits;
    end
    d_full    = pmb_clamped - 1'b1;
    word_bits = d_full[D_W-1:0];
  end

  rbp_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .clear     (cfg_we),
    .word_bits (word_bits),
    .byte_in   (byte_in),
    .out_free  (out_free),
    .emit      (emit)
  );

  rbp_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .emit     (emit),
    .out_free (out_free),
    .word_out (word_out)
  );

endmodule

### verif/tb_byte_to_slot_bit_repacker_unit.sv
// Testbench for byte_to_slot_bit_repacker_unit: drives bytes and segment ends, predicts
// the packed slot words in a local model and checks each word as it leaves the unit.
// Depends on rbp_pkg, rbp_ifs and the unit itself.
`timescale 1ns / 100ps

module tb_byte_to_slot_bit_repacker_unit;
  import rbp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic              last;
  } slot_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic accept_en = 1'b0;

  rbp_byte_if byte_ch ();
  rbp_word_if word_ch ();

  assign word_ch.ready = accept_en;

  byte_to_slot_bit_repacker_unit uut (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_ch),
    .word_out  (word_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  slot_result_t slot_words_due[$];
  logic [CFG_W-1:0] pmb_setting = PMB_RESET;
  logic [ACC_W-1:0] pending_bits = '0;
  int pending_count = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int bytes_sent = 0;
  int words_checked = 0;
  int segments_closed = 0;
  int settings_written = 0;
  int mismatches = 0;
  int cycle_count = 0;

  function automatic logic [63:0] low_ones(input int n);
    return (64'd1 << n) - 64'd1;
  endfunction

  function automatic int slot_width();
    logic [CFG_W-1:0] p;
    p = pmb_setting;
    if (p < PMB_MIN) p = PMB_MIN;
    if (p > PMB_MAX) p = PMB_MAX;
    return int'(p) - 1;
  endfunction

  function automatic void repack_byte(input logic [BYTE_W-1:0] data, input logic eos);
    slot_result_t produced[$];
    slot_result_t r;
    logic [63:0] w;
    int d;
    int shift;
    int pad;
    d = slot_width();
    pending_bits = {pending_bits[ACC_W-BYTE_W-1:0], data};
    pending_count += BYTE_W;
    while (pending_count >= d && produced.size() < 8) begin
      shift = pending_count - d;
      w = (64'(pending_bits) >> shift) & low_ones(d);
      r.word = w[WORD_W-1:0];
      r.last = 1'b0;
      produced = {produced, r};
      pending_count = shift;
      pending_bits = pending_bits & ACC_W'(low_ones(pending_count));
    end
    if (eos) begin
      if (pending_count > 0) begin
        pad = d - pending_count;
        w = ((64'(pending_bits) << pad) | low_ones(pad)) & low_ones(d);
        r.word = w[WORD_W-1:0];
        r.last = 1'b1;
        produced = {produced, r};
        pending_count = 0;
        pending_bits = '0;
      end else if (produced.size() > 0) begin
        produced[produced.size()-1].last = 1'b1;
      end
    end
    slot_words_due = {slot_words_due, produced};
  endfunction

  always @(posedge clk) begin
    slot_result_t due;
    if (rst) begin
      accept_en <= 1'b0;
    end else begin
      if (word_ch.valid && word_ch.ready) begin
        if (slot_words_due.size() == 0) begin
          $error("unexpected word: slot_word %h segment_last %b",
                 word_ch.slot_word, word_ch.segment_last);
          mismatches++;
        end else begin
          due = slot_words_due.pop_front();
          if (word_ch.slot_word !== due.word) begin
            $error("slot_word: expected %h, got %h", due.word, word_ch.slot_word);
            mismatches++;
          end
          if (word_ch.segment_last !== due.last) begin
            $error("segment_last: expected %b, got %b", due.last, word_ch.segment_last);
            mismatches++;
          end
          if (due.last) segments_closed++;
          words_checked++;
        end
      end
      accept_en <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_byte_to_slot_bit_repacker_unit NOT OK");
    $finish;
  end

  task automatic send_request(input logic [BYTE_W-1:0] data, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.data_byte <= data;
    byte_ch.end_of_segment <= eos;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    repack_byte(data, eos);
    bytes_sent++;
  endtask

  task automatic drain_results();
    byte_ch.valid <= 1'b0;
    while (slot_words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_setting(input logic [CFG_W-1:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    pmb_setting = value;
    pending_bits = '0;
    pending_count = 0;
    settings_written++;
  endtask

  task automatic test_reset_setting();
    send_request(8'hA5, 1'b0);
    send_request(8'h3C, 1'b0);
    send_request(8'hFF, 1'b1);
  endtask

  task automatic test_register_extremes();
    write_setting(6'd0);
    send_request(8'hFF, 1'b1);
    send_request(8'h00, 1'b1);
    write_setting(6'd63);
    send_request(8'h80, 1'b0);
    send_request(8'h01, 1'b0);
    send_request(8'h7F, 1'b0);
    send_request(8'hFE, 1'b1);
    write_setting(PMB_MAX);
    send_request(8'h00, 1'b0);
    send_request(8'h55, 1'b1);
    write_setting(6'd33);
    send_request(8'hC3, 1'b1);
    write_setting(PMB_MIN);
    send_request(8'hAA, 1'b1);
    write_setting(6'd1);
    send_request(8'h5A, 1'b1);
  endtask

  task automatic test_word_boundary();
    write_setting(6'd9);
    send_request(8'h12, 1'b0);
    send_request(8'h34, 1'b1);
    write_setting(6'd17);
    send_request(8'hDE, 1'b0);
    send_request(8'hAD, 1'b1);
  endtask

  task automatic test_write_drops_partial();
    write_setting(6'd13);
    send_request(8'hF0, 1'b0);
    send_request(8'h0F, 1'b0);
    write_setting(6'd13);
    send_request(8'hC3, 1'b1);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int byte_budget);
    int target;
    int segs;
    int len;
    int pick;
    logic eos;
    logic close_chunk;
    target = bytes_sent + byte_budget;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    while (bytes_sent < target) begin
      pick = $urandom_range(9);
      if (pick == 0) write_setting(CFG_W'($urandom_range(63)));
      else if (pick == 1) write_setting(CFG_W'($urandom_range(8, 2)));
      else write_setting(CFG_W'($urandom_range(32, 9)));
      segs = $urandom_range(4, 1);
      close_chunk = ($urandom_range(3) != 0);
      for (int s = 0; s < segs; s++) begin
        len = (slot_width() < BYTE_W) ? $urandom_range(4, 1) : $urandom_range(12, 1);
        for (int b = 0; b < len; b++) begin
          if (b == len - 1 && (s < segs - 1 || close_chunk)) eos = 1'b1;
          else eos = ($urandom_range(15) == 0);
          send_request(BYTE_W'($urandom_range(255)), eos);
        end
        if (s == 0 && $urandom_range(3) == 0) drain_results();
      end
    end
  endtask

  initial begin
    byte_ch.valid <= 1'b0;
    byte_ch.data_byte <= '0;
    byte_ch.end_of_segment <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 36;
    recv_stall_pct = 87;
    test_reset_setting();
    test_register_extremes();
    test_word_boundary();
    test_write_drops_partial();
    test_random_traffic(36, 87, 90);
    test_random_traffic(87, 36, 90);
    test_random_traffic(0, 0, 90);
    drain_results();
    $display("Run covered %0d bytes over %0d register writes, from narrow to full-width slots.",
             bytes_sent, settings_written);
    $display("Checked %0d slot words, %0d of them closing a segment.",
             words_checked, segments_closed);
    if (mismatches == 0) begin
      $display("tb_byte_to_slot_bit_repacker_unit OK");
    end else begin
      $display("tb_byte_to_slot_bit_repacker_unit NOT OK");
    end
    $finish;
  end

endmodule
